// ===== hdl/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhp_pkg: HTTP response header parser package
// Shared types, result codes, character constants and the prefix table.
// ----------------------------------------------------------------------------
package hrhp_pkg;

   localparam int PREFIX_LEN  = 9;
   localparam int CODE_W      = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CODE_W-1:0] CODE_MAX = 16'd32767;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_KEY   = 3'd1,
      KIND_VALUE = 3'd2,
      KIND_ENTRY = 3'd3,
      KIND_DROP  = 3'd4,
      KIND_OK    = 3'd5,
      KIND_ERR   = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_STATUS,
      PH_KEY,
      PH_COLON,
      PH_VALUE,
      PH_DRAIN
   } phase_type;

   typedef enum logic [1:0] {
      NP_SKIP,
      NP_SIGN,
      NP_DIGITS,
      NP_STOP
   } num_phase_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         data_byte;
      logic [CODE_W-1:0]  status_code;
      logic               run_end;
   } result_type;

   // Results produced by one byte, handed to the output queue
   typedef struct packed {
      logic [1:0]  count;
      result_type  res0;
      result_type  res1;
   } push_type;

   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h48; // H
         4'd1:    ch = 8'h54; // T
         4'd2:    ch = 8'h54; // T
         4'd3:    ch = 8'h50; // P
         4'd4:    ch = 8'h2F; // /
         4'd5:    ch = 8'h31; // 1
         4'd6:    ch = 8'h2E; // .
         4'd7:    ch = 8'h31; // 1
         4'd8:    ch = CH_SPACE;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== hdl/hrhp_core.sv =====
// ----------------------------------------------------------------------------
// hrhp_core: parser state and per-byte decode
// Holds the parse state and works out the results of each byte, at most two.
// ----------------------------------------------------------------------------
module hrhp_core
   import hrhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  byte_in,
   input  logic        end_of_buffer,
   output push_type    push
);

   phase_type          phase_ff, phase_in;
   logic [3:0]         prefix_idx_ff, prefix_idx_in;
   num_phase_type      num_ph_ff, num_ph_in;
   logic               negative_ff, negative_in;
   logic [CODE_W-1:0]  acc_ff, acc_in;
   logic [1:0]         key_len_ff, key_len_in;
   logic [1:0]         val_len_ff, val_len_in;
   logic [1:0]         after_colon_ff, after_colon_in;

   logic               is_digit, is_ws, is_eol;
   logic [19:0]        acc_times10;
   logic [CODE_W-1:0]  code_bits, digit_val;
   logic               have0, final_res, ok_at_end;
   kind_type           kind0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_PREFIX;
         prefix_idx_ff  <= '0;
         num_ph_ff      <= NP_SKIP;
         negative_ff    <= 1'b0;
         acc_ff         <= '0;
         key_len_ff     <= '0;
         val_len_ff     <= '0;
         after_colon_ff <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         prefix_idx_ff  <= prefix_idx_in;
         num_ph_ff      <= num_ph_in;
         negative_ff    <= negative_in;
         acc_ff         <= acc_in;
         key_len_ff     <= key_len_in;
         val_len_ff     <= val_len_in;
         after_colon_ff <= after_colon_in;
      end
   end

   assign is_digit    = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
   assign is_ws       = byte_in inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
   assign is_eol      = byte_in inside {CH_CR, CH_LF};
   assign digit_val   = {8'd0, byte_in - CH_ZERO};
   assign acc_times10 = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                        + {4'd0, digit_val};
   // accumulator never exceeds the saturation limit, so negate it directly
   assign code_bits   = negative_ff ? (~acc_ff + 16'd1) : acc_ff;

   always_comb begin
      phase_in       = phase_ff;
      prefix_idx_in  = prefix_idx_ff;
      num_ph_in      = num_ph_ff;
      negative_in    = negative_ff;
      acc_in         = acc_ff;
      key_len_in     = key_len_ff;
      val_len_in     = val_len_ff;
      after_colon_in = after_colon_ff;
      have0          = 1'b0;
      kind0          = KIND_NONE;
      final_res      = 1'b0;
      ok_at_end      = 1'b0;

      case (phase_ff)
         PH_PREFIX: begin
            if (prefix_idx_ff >= 4'(PREFIX_LEN) || byte_in != prefix_char(prefix_idx_ff)) begin
               have0     = 1'b1;
               kind0     = KIND_ERR;
               final_res = 1'b1;
            end else begin
               prefix_idx_in = prefix_idx_ff + 4'd1;
               if (prefix_idx_in == 4'(PREFIX_LEN)) phase_in = PH_STATUS;
               if (end_of_buffer) begin
                  have0     = 1'b1;
                  kind0     = KIND_ERR;
                  final_res = 1'b1;
               end
            end
         end
         PH_STATUS: begin
            if (byte_in == CH_LF) begin
               if (end_of_buffer || acc_ff == '0) begin
                  have0     = 1'b1;
                  kind0     = KIND_ERR;
                  final_res = 1'b1;
               end else begin
                  phase_in       = PH_KEY;
                  key_len_in     = '0;
                  val_len_in     = '0;
                  after_colon_in = '0;
               end
            end else begin
               case (num_ph_ff)
                  NP_SKIP: begin
                     if (is_ws) begin
                        num_ph_in = NP_SKIP;
                     end else if (byte_in == CH_PLUS) begin
                        num_ph_in = NP_SIGN;
                     end else if (byte_in == CH_MINUS) begin
                        negative_in = 1'b1;
                        num_ph_in   = NP_SIGN;
                     end else if (is_digit) begin
                        acc_in    = digit_val;
                        num_ph_in = NP_DIGITS;
                     end else begin
                        num_ph_in = NP_STOP;
                     end
                  end
                  NP_SIGN: begin
                     if (is_digit) begin
                        acc_in    = digit_val;
                        num_ph_in = NP_DIGITS;
                     end else begin
                        num_ph_in = NP_STOP;
                     end
                  end
                  NP_DIGITS: begin
                     if (is_digit) begin
                        acc_in = (acc_times10 > {4'd0, CODE_MAX}) ? CODE_MAX
                                                                  : acc_times10[CODE_W-1:0];
                     end else begin
                        num_ph_in = NP_STOP;
                     end
                  end
                  default: num_ph_in = num_ph_ff;
               endcase
               if (end_of_buffer) begin
                  have0     = 1'b1;
                  kind0     = KIND_ERR;
                  final_res = 1'b1;
               end
            end
         end
         PH_KEY: begin
            if (byte_in == CH_NUL) begin
               have0     = 1'b1;
               kind0     = KIND_OK;
               final_res = 1'b1;
            end else if (byte_in == CH_COLON) begin
               if (key_len_ff == '0 || end_of_buffer) begin
                  have0     = 1'b1;
                  kind0     = KIND_ERR;
                  final_res = 1'b1;
               end else begin
                  phase_in       = PH_COLON;
                  after_colon_in = 2'd1;
               end
            end else if (is_eol) begin
               if (key_len_ff >= 2'd2) begin
                  have0     = 1'b1;
                  kind0     = KIND_ERR;
                  final_res = 1'b1;
               end else begin
                  if (key_len_ff == 2'd1) begin
                     have0 = 1'b1;
                     kind0 = KIND_DROP;
                  end
                  key_len_in = '0;
                  ok_at_end  = 1'b1;
               end
            end else begin
               have0 = 1'b1;
               kind0 = KIND_KEY;
               if (key_len_ff < 2'd2) key_len_in = key_len_ff + 2'd1;
               ok_at_end = 1'b1;
            end
         end
         PH_COLON: begin
            if (after_colon_ff == 2'd1 && byte_in == CH_SPACE) begin
               if (end_of_buffer) begin
                  have0     = 1'b1;
                  kind0     = KIND_ERR;
                  final_res = 1'b1;
               end else begin
                  after_colon_in = 2'd2;
               end
            end else begin
               // first value byte is taken whatever it is
               have0          = 1'b1;
               kind0          = KIND_VALUE;
               after_colon_in = '0;
               val_len_in     = 2'd1;
               phase_in       = PH_VALUE;
               ok_at_end      = 1'b1;
            end
         end
         PH_VALUE: begin
            if (byte_in == CH_NUL) begin
               have0     = 1'b1;
               kind0     = KIND_OK;
               final_res = 1'b1;
            end else if (is_eol) begin
               if (val_len_ff == '0) begin
                  have0     = 1'b1;
                  kind0     = KIND_ERR;
                  final_res = 1'b1;
               end else begin
                  have0      = 1'b1;
                  kind0      = KIND_ENTRY;
                  key_len_in = '0;
                  val_len_in = '0;
                  phase_in   = PH_KEY;
                  ok_at_end  = 1'b1;
               end
            end else begin
               have0 = 1'b1;
               kind0 = KIND_VALUE;
               if (val_len_ff < 2'd2) val_len_in = val_len_ff + 2'd1;
               ok_at_end = 1'b1;
            end
         end
         default: begin
            phase_in = PH_DRAIN;
         end
      endcase

      if (ok_at_end && end_of_buffer) final_res = 1'b1;

      // a final result on the buffer end, or a buffer end while draining, returns to the reset state
      if ((final_res || phase_ff == PH_DRAIN) && end_of_buffer) begin
         phase_in       = PH_PREFIX;
         prefix_idx_in  = '0;
         num_ph_in      = NP_SKIP;
         negative_in    = 1'b0;
         acc_in         = '0;
         key_len_in     = '0;
         val_len_in     = '0;
         after_colon_in = '0;
      end else if (final_res) begin
         phase_in = PH_DRAIN;
      end
   end

   // assemble the results of this byte
   always_comb begin
      result_type r0, r1;
      logic       second;
      second = ok_at_end && end_of_buffer && have0;
      r0 = '0;
      r1 = '0;
      if (have0) begin
         r0.kind = kind0;
      end else begin
         r0.kind = KIND_OK;
      end
      if (r0.kind == KIND_KEY || r0.kind == KIND_VALUE) r0.data_byte = byte_in;
      if (r0.kind == KIND_OK) r0.status_code = code_bits;
      r0.run_end     = !second;
      r1.kind        = KIND_OK;
      r1.status_code = code_bits;
      r1.run_end     = 1'b1;
      push.res0  = r0;
      push.res1  = r1;
      if (!step) begin
         push.count = 2'd0;
      end else if (second) begin
         push.count = 2'd2;
      end else if (have0 || (ok_at_end && end_of_buffer)) begin
         push.count = 2'd1;
      end else begin
         push.count = 2'd0;
      end
   end

endmodule

// ===== hdl/hrhp_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// hrhp_rsp_queue: result queue
// Small register queue taking up to two results per cycle, giving one when not stalled.
// ----------------------------------------------------------------------------
module hrhp_rsp_queue
   import hrhp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   output logic        room,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output result_type  rsp_head
);

   localparam int AW = $clog2(DEPTH);

   result_type        mem_ff [DEPTH];
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [AW:0]       count_ff, count_in;
   logic              pop;
   logic [AW-1:0]     tail_next;

   assign rsp_valid = (count_ff != '0);
   assign rsp_head  = mem_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for a full two-result transfer
   assign room      = (count_ff <= (AW+1)'(DEPTH - 2));
   assign tail_next = tail_ff + AW'(1);

   always_comb begin
      head_in  = pop ? head_ff + AW'(1) : head_ff;
      tail_in  = tail_ff + AW'(push.count);
      count_in = count_ff + (AW+1)'(push.count) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[tail_ff] <= push.res0;
      if (push.count == 2'd2) mem_ff[tail_next] <= push.res1;
   end

endmodule

// ===== hdl/http_response_header_parser.sv =====
// ----------------------------------------------------------------------------
// http_response_header_parser: streaming HTTP/1.1 response header parser
// Checks the status line, reads the status code and streams header entries.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless the input stalls. A byte is registered,
// decoded against the parse state once the result queue has room, and its
// results enter a result queue of DEPTH entries (four by default) that
// delivers one result per cycle while rsp_stall is low. Bytes that cause two
// results (a header byte or line end on the buffer end) are limited by the
// single result port, so a long run of them stalls the input; all other bytes
// go through at one per cycle with no result-side stall.
module http_response_header_parser
   import hrhp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_byte_in,
   input  logic               req_end_of_buffer,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_data_byte,
   output logic signed [15:0] rsp_status_code,
   output logic               rsp_run_end
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_eob_ff;
   logic        room, step, req_take;
   push_type    push;
   result_type  head;

   assign step      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_byte_in;
         in_eob_ff  <= req_end_of_buffer;
      end
   end

   hrhp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .byte_in       (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .push          (push)
   );

   hrhp_rsp_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_head  (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_data_byte   = head.data_byte;
   assign rsp_status_code = head.status_code;
   assign rsp_run_end     = head.run_end;

endmodule
